>>> rtl/core/nearest_centroid_point_clusterer_defines.svh
// assertion macros for the nearest centroid point clusterer
// no dependencies
`ifndef NEAREST_CENTROID_POINT_CLUSTERER_DEFINES_SVH
`define NEAREST_CENTROID_POINT_CLUSTERER_DEFINES_SVH
// implication checked on every rising clock edge outside reset
`define NCPC_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> (c)) \
    else $error("assertion failed");
// next-cycle implication outside reset
`define NCPC_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |=> (c)) \
    else $error("assertion failed");
`endif

>>> rtl/core/ncpc_pkg.sv
// package for the nearest centroid point clusterer: sizes, codes, states
// no dependencies
package ncpc_pkg;
  localparam int MaxClusters = 64;
  localparam int IdxBits = 6;
  localparam int LiveBits = 7;
  localparam int CountBits = 16;
  localparam int CoordBits = 16;
  localparam int SumBits = 32;
  localparam int TolBits = 34;

  typedef enum logic [2:0] {
    StJoined = 3'd0, StNew = 3'd1, StFull = 3'd2, StSat = 3'd3, StClear = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    FsIdle, FsRead, FsDist, FsCmp, FsDecide, FsRdBest, FsUpd, FsDiv, FsWrite, FsOut
  } fsm_e;
endpackage

>>> rtl/core/nearest_centroid_point_clusterer.sv
// top level of the nearest centroid point clusterer
// depends on ncpc_pkg and nearest_centroid_point_clusterer_defines.svh
//
//  channel | direction | handshake
//  in      | input     | in_valid_i / in_ready_o
//  out     | output    | out_valid_o / out_ready_i
//  cfg     | input     | apb psel/penable/pwrite, pready tied high
//
// an add beat is taken through read, distance and compare states for each live cluster,
// then opens a cluster, or reads the best one and reports a saturated count or runs the
// two bit-serial divides, run together, before writing it back
// a clear beat goes straight to the output state; reset needs no clearing pass
// the next input beat is taken once the result in the output register has left
`include "nearest_centroid_point_clusterer_defines.svh"
module nearest_centroid_point_clusterer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        action_i,
  input  logic signed [15:0] point_x_i,
  input  logic signed [15:0] point_y_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [5:0]  cluster_index_o,
  output logic signed [15:0] centroid_x_o,
  output logic signed [15:0] centroid_y_o,
  output logic [15:0] member_total_o,
  output logic [6:0]  clusters_live_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  // memories: centroid pair and sums/count
  logic [31:0] cent_mem [ncpc_pkg::MaxClusters];
  logic [79:0] sum_mem [ncpc_pkg::MaxClusters];
  logic [31:0] cent_rd_q;
  logic [79:0] sum_rd_q;

  ncpc_pkg::fsm_e state_q, state_d;
  logic [33:0] tol_q;
  logic [6:0]  live_q, live_d;
  logic [6:0]  scan_q, scan_d;
  logic [5:0]  best_q, best_d;
  logic        found_q, found_d;
  logic [33:0] bestd_q, bestd_d;
  logic signed [15:0] px_q, py_q;
  logic [16:0] dx_q, dy_q;
  logic [31:0] sx_q, sy_q;
  logic [15:0] cnt_q;
  logic [5:0]  dcnt_q;
  logic [31:0] qx_q, qy_q;
  logic [16:0] rx_q, ry_q;
  logic        negx_q, negy_q;
  logic        out_valid_q;
  logic [2:0]  o_status_q;
  logic [5:0]  o_idx_q;
  logic [15:0] o_cx_q, o_cy_q, o_cnt_q;
  logic [6:0]  o_live_q;

  // config port
  assign pready = 1'b1;
  assign prdata = {30'd0, tol_q};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= 34'd32768;
    end else if (psel && penable && pwrite && paddr == 3'd0) begin
      tol_q <= pwdata[33:0];
    end
  end

  logic in_acc, out_acc;
  assign in_ready_o = (state_q == ncpc_pkg::FsIdle) && !out_valid_q;
  assign in_acc = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  // squared distance of registered differences, each below 2^32 so sum fits 34
  logic [31:0] sqx_c, sqy_c;
  logic [33:0] dist_c;
  assign sqx_c = dx_q[15:0] * dx_q[15:0];
  assign sqy_c = dy_q[15:0] * dy_q[15:0];
  assign dist_c = {2'b00, sqx_c} + {2'b00, sqy_c}
                + {1'b0, dx_q[16], 32'd0} + {1'b0, dy_q[16], 32'd0};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ncpc_pkg::FsIdle:   if (in_acc) state_d = action_i ? ncpc_pkg::FsOut :
                            (live_q == 7'd0 ? ncpc_pkg::FsDecide : ncpc_pkg::FsRead);
      ncpc_pkg::FsRead:   state_d = ncpc_pkg::FsDist;
      ncpc_pkg::FsDist:   state_d = ncpc_pkg::FsCmp;
      ncpc_pkg::FsCmp:    state_d = (scan_q == live_q) ? ncpc_pkg::FsDecide :
                                                         ncpc_pkg::FsRead;
      ncpc_pkg::FsDecide: state_d = found_q ? ncpc_pkg::FsRdBest : ncpc_pkg::FsOut;
      ncpc_pkg::FsRdBest: state_d = ncpc_pkg::FsUpd;
      ncpc_pkg::FsUpd:    state_d = (sum_rd_q[15:0] == 16'hFFFF) ? ncpc_pkg::FsOut :
                                                                  ncpc_pkg::FsDiv;
      ncpc_pkg::FsDiv:    state_d = (dcnt_q == 6'd31) ? ncpc_pkg::FsWrite : ncpc_pkg::FsDiv;
      ncpc_pkg::FsWrite:  state_d = ncpc_pkg::FsOut;
      ncpc_pkg::FsOut:    state_d = ncpc_pkg::FsIdle;
      default:            state_d = ncpc_pkg::FsIdle;
    endcase
  end

  // search bookkeeping
  always_comb begin
    scan_d = scan_q;
    best_d = best_q;
    found_d = found_q;
    bestd_d = bestd_q;
    live_d = live_q;
    case (state_q)
      ncpc_pkg::FsIdle: begin
        scan_d = 7'd0;
        found_d = 1'b0;
        bestd_d = tol_q;
        best_d = 6'd0;
        if (in_acc && action_i) live_d = 7'd0;
      end
      ncpc_pkg::FsCmp: begin
        if (dist_c < bestd_q) begin
          bestd_d = dist_c;
          best_d = scan_q[5:0] - 6'd1;
          found_d = 1'b1;
        end
      end
      ncpc_pkg::FsDecide: begin
        if (!found_q && live_q != 7'(ncpc_pkg::MaxClusters)) live_d = live_q + 7'd1;
      end
      default: ;
    endcase
  end

  // divider step: restoring divide of magnitudes by the new count
  logic [16:0] trx, try_;
  logic [32:0] qx_neg, qy_neg;
  assign trx = {rx_q[15:0], qx_q[31]};
  assign try_ = {ry_q[15:0], qy_q[31]};

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ncpc_pkg::FsIdle: if (in_acc) begin
        px_q <= point_x_i;
        py_q <= point_y_i;
      end
      ncpc_pkg::FsDist: begin
        dx_q <= (px_q >= $signed(cent_rd_q[15:0])) ?
                17'({px_q[15], px_q} - {cent_rd_q[15], cent_rd_q[15:0]}) :
                17'({cent_rd_q[15], cent_rd_q[15:0]} - {px_q[15], px_q});
        dy_q <= (py_q >= $signed(cent_rd_q[31:16])) ?
                17'({py_q[15], py_q} - {cent_rd_q[31], cent_rd_q[31:16]}) :
                17'({cent_rd_q[31], cent_rd_q[31:16]} - {py_q[15], py_q});
      end
      ncpc_pkg::FsUpd: begin
        sx_q <= sum_rd_q[79:48] + {{16{px_q[15]}}, px_q};
        sy_q <= sum_rd_q[47:16] + {{16{py_q[15]}}, py_q};
        cnt_q <= sum_rd_q[15:0] + 16'd1;
        begin
          logic [31:0] ax, ay;
          ax = sum_rd_q[79:48] + {{16{px_q[15]}}, px_q};
          ay = sum_rd_q[47:16] + {{16{py_q[15]}}, py_q};
          negx_q <= ax[31];
          negy_q <= ay[31];
          qx_q <= ax[31] ? 32'(-ax) : ax;
          qy_q <= ay[31] ? 32'(-ay) : ay;
        end
        rx_q <= 17'd0;
        ry_q <= 17'd0;
        dcnt_q <= 6'd0;
      end
      ncpc_pkg::FsDiv: begin
        dcnt_q <= dcnt_q + 6'd1;
        if (trx >= {1'b0, cnt_q}) begin
          rx_q <= trx - {1'b0, cnt_q};
          qx_q <= {qx_q[30:0], 1'b1};
        end else begin
          rx_q <= trx;
          qx_q <= {qx_q[30:0], 1'b0};
        end
        if (try_ >= {1'b0, cnt_q}) begin
          ry_q <= try_ - {1'b0, cnt_q};
          qy_q <= {qy_q[30:0], 1'b1};
        end else begin
          ry_q <= try_;
          qy_q <= {qy_q[30:0], 1'b0};
        end
      end
      default: ;
    endcase
  end
  assign qx_neg = negx_q ? 33'(-{1'b0, qx_q}) : {1'b0, qx_q};
  assign qy_neg = negy_q ? 33'(-{1'b0, qy_q}) : {1'b0, qy_q};

  // memory read port, address chosen by state
  logic [5:0] rd_addr;
  assign rd_addr = (state_q == ncpc_pkg::FsDecide || state_q == ncpc_pkg::FsRdBest) ?
                   best_q : scan_q[5:0];
  always_ff @(posedge clk_i) begin
    cent_rd_q <= cent_mem[rd_addr];
    sum_rd_q <= sum_mem[rd_addr];
  end

  // memory write: new cluster at decide, update at write
  always_ff @(posedge clk_i) begin
    if (state_q == ncpc_pkg::FsDecide && !found_q &&
        live_q != 7'(ncpc_pkg::MaxClusters)) begin
      cent_mem[live_q[5:0]] <= {py_q, px_q};
      sum_mem[live_q[5:0]] <= {{16{px_q[15]}}, px_q, {16{py_q[15]}}, py_q, 16'd1};
    end else if (state_q == ncpc_pkg::FsWrite) begin
      cent_mem[best_q] <= {qy_neg[15:0], qx_neg[15:0]};
      sum_mem[best_q] <= {sx_q, sy_q, cnt_q};
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ncpc_pkg::FsIdle;
      live_q <= 7'd0;
      scan_q <= 7'd0;
      best_q <= 6'd0;
      found_q <= 1'b0;
      bestd_q <= 34'd0;
    end else begin
      state_q <= state_d;
      live_q <= live_d;
      scan_q <= (state_q == ncpc_pkg::FsRead) ? scan_q + 7'd1 : scan_d;
      best_q <= best_d;
      found_q <= found_d;
      bestd_q <= bestd_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      if (out_acc) out_valid_q <= 1'b0;
      if (state_q == ncpc_pkg::FsOut) out_valid_q <= 1'b1;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (state_q == ncpc_pkg::FsIdle && in_acc && action_i) begin
      o_status_q <= ncpc_pkg::StClear;
      o_idx_q <= 6'd0; o_cx_q <= 16'd0; o_cy_q <= 16'd0; o_cnt_q <= 16'd0;
    end else if (state_q == ncpc_pkg::FsDecide && !found_q) begin
      if (live_q == 7'(ncpc_pkg::MaxClusters)) begin
        o_status_q <= ncpc_pkg::StFull;
        o_idx_q <= 6'd0; o_cx_q <= 16'd0; o_cy_q <= 16'd0; o_cnt_q <= 16'd0;
      end else begin
        o_status_q <= ncpc_pkg::StNew;
        o_idx_q <= live_q[5:0]; o_cx_q <= px_q; o_cy_q <= py_q; o_cnt_q <= 16'd1;
      end
    end else if (state_q == ncpc_pkg::FsUpd) begin
      o_status_q <= ncpc_pkg::StSat;
      o_idx_q <= best_q;
      o_cx_q <= cent_rd_q[15:0]; o_cy_q <= cent_rd_q[31:16];
      o_cnt_q <= sum_rd_q[15:0];
    end else if (state_q == ncpc_pkg::FsWrite) begin
      o_status_q <= ncpc_pkg::StJoined;
      o_cx_q <= qx_neg[15:0]; o_cy_q <= qy_neg[15:0]; o_cnt_q <= cnt_q;
    end
    if (state_q == ncpc_pkg::FsOut) o_live_q <= live_q;
  end

  assign out_valid_o = out_valid_q;
  assign status_o = o_status_q;
  assign cluster_index_o = o_idx_q;
  assign centroid_x_o = o_cx_q;
  assign centroid_y_o = o_cy_q;
  assign member_total_o = o_cnt_q;
  assign clusters_live_o = o_live_q;

  `NCPC_ASSERT_IMP(a_live_bound, 1'b1, live_q <= 7'(ncpc_pkg::MaxClusters))
  `NCPC_ASSERT_IMP(a_no_take_busy, out_valid_q, !in_ready_o)
  `NCPC_ASSERT_NXT(a_out_after, state_q == ncpc_pkg::FsOut, out_valid_q)
  `NCPC_ASSERT_IMP(a_best_live, found_q, {1'b0, best_q} < live_q)
endmodule

>>> sim/nearest_centroid_point_clusterer_tb.sv
// self-checking testbench for the nearest centroid point clusterer
// depends on ncpc_pkg and the nearest_centroid_point_clusterer top level
module nearest_centroid_point_clusterer_tb;

  typedef struct packed {
    logic               action;
    logic signed [15:0] px;
    logic signed [15:0] py;
  } point_beat_t;

  typedef struct packed {
    ncpc_pkg::status_e  status;
    logic [5:0]         idx;
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic [15:0]        members;
    logic [6:0]         live;
  } cluster_result_t;

  localparam int CycleLimit = 3000000;
  localparam int SettleCycles = 400;

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o, action_i;
  logic signed [15:0] point_x_i, point_y_i;
  logic out_valid_o, out_ready_i;
  logic [2:0] status_o;
  logic [5:0] cluster_index_o;
  logic signed [15:0] centroid_x_o, centroid_y_o;
  logic [15:0] member_total_o;
  logic [6:0] clusters_live_o;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [63:0] pwdata, prdata;

  nearest_centroid_point_clusterer u_dut (.*);

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // shadow copy of the cluster table
  logic [ncpc_pkg::TolBits-1:0] tol_sq;
  int               table_live;
  longint           sum_x_tbl [ncpc_pkg::MaxClusters];
  longint           sum_y_tbl [ncpc_pkg::MaxClusters];
  longint           cen_x_tbl [ncpc_pkg::MaxClusters];
  longint           cen_y_tbl [ncpc_pkg::MaxClusters];
  longint unsigned  count_tbl [ncpc_pkg::MaxClusters];

  point_beat_t     pending_q[$];
  cluster_result_t centroid_q[$];
  int errors, cycles, points_sent, results_seen, full_seen, new_seen, joined_seen;
  logic quiet, hold_send, in_fire;

  // work out the result of one beat and update the table copy
  task automatic cluster_point(input point_beat_t b);
    longint px, py, dx, dy;
    longint unsigned d, best_d;
    int best;
    bit found;
    cluster_result_t r;
    r = '0;
    if (b.action) begin
      table_live = 0;
      r.status = ncpc_pkg::StClear;
      centroid_q.push_back(r);
      return;
    end
    px = b.px;
    py = b.py;
    best_d = tol_sq;
    best = 0;
    found = 1'b0;
    for (int i = 0; i < table_live; i++) begin
      dx = cen_x_tbl[i] - px;
      dy = cen_y_tbl[i] - py;
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      d = longint'(dx * dx) + longint'(dy * dy);
      if (d < best_d) begin
        best_d = d;
        best = i;
        found = 1'b1;
      end
    end
    if (!found && table_live >= ncpc_pkg::MaxClusters) begin
      r.status = ncpc_pkg::StFull;
      r.live = 7'(table_live);
    end else if (!found) begin
      best = table_live;
      table_live++;
      sum_x_tbl[best] = px;
      sum_y_tbl[best] = py;
      count_tbl[best] = 1;
      cen_x_tbl[best] = px;
      cen_y_tbl[best] = py;
      r.status = ncpc_pkg::StNew;
    end else if (count_tbl[best] >= (1 << ncpc_pkg::CountBits) - 1) begin
      r.status = ncpc_pkg::StSat;
    end else begin
      sum_x_tbl[best] += px;
      sum_y_tbl[best] += py;
      count_tbl[best] += 1;
      cen_x_tbl[best] = sum_x_tbl[best] / longint'(count_tbl[best]);
      cen_y_tbl[best] = sum_y_tbl[best] / longint'(count_tbl[best]);
      r.status = ncpc_pkg::StJoined;
    end
    if (r.status != ncpc_pkg::StFull) begin
      r.idx = 6'(best);
      r.cx = 16'(cen_x_tbl[best]);
      r.cy = 16'(cen_y_tbl[best]);
      r.members = 16'(count_tbl[best]);
      r.live = 7'(table_live);
    end
    centroid_q.push_back(r);
  endtask

  // input driver: new beat at the falling edge once the last one was taken
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_fire)) begin
      if (pending_q.size() > 0 && !hold_send && (quiet || $urandom_range(99) >= 9)) begin
        point_beat_t b;
        b = pending_q.pop_front();
        in_valid_i <= 1'b1;
        action_i   <= b.action;
        point_x_i  <= b.px;
        point_y_i  <= b.py;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_ready_i <= quiet || $urandom_range(99) >= 9;
  end

  // monitor: predict on accepted input beats, check accepted output beats
  always @(posedge clk_i) begin
    in_fire = 1'b0;
    if (rst_ni) begin
      cycles++;
      if (cycles > CycleLimit) begin
        $display("%0t timeout with %0d results pending", $time, centroid_q.size());
        $display("simulation failed");
        $finish;
      end
      if (in_valid_i && in_ready_o) begin
        in_fire = 1'b1;
        points_sent++;
        cluster_point({action_i, point_x_i, point_y_i});
      end
      if (out_valid_o && out_ready_i) begin
        cluster_result_t e;
        results_seen++;
        if (centroid_q.size() == 0) begin
          $display("%0t unexpected result beat, status %0d", $time, status_o);
          errors++;
        end else begin
          e = centroid_q.pop_front();
          if (e.status == ncpc_pkg::StFull) full_seen++;
          if (e.status == ncpc_pkg::StNew) new_seen++;
          if (e.status == ncpc_pkg::StJoined) joined_seen++;
          if (status_o != e.status) begin
            $display("%0t status exp %0d got %0d", $time, e.status, status_o);
            errors++;
          end
          if (cluster_index_o != e.idx) begin
            $display("%0t cluster_index exp %0d got %0d", $time, e.idx, cluster_index_o);
            errors++;
          end
          if (centroid_x_o != e.cx) begin
            $display("%0t centroid_x exp %0d got %0d", $time, e.cx, centroid_x_o);
            errors++;
          end
          if (centroid_y_o != e.cy) begin
            $display("%0t centroid_y exp %0d got %0d", $time, e.cy, centroid_y_o);
            errors++;
          end
          if (member_total_o != e.members) begin
            $display("%0t member_total exp %0d got %0d", $time, e.members, member_total_o);
            errors++;
          end
          if (clusters_live_o != e.live) begin
            $display("%0t clusters_live exp %0d got %0d", $time, e.live, clusters_live_o);
            errors++;
          end
        end
      end
    end
  end

  task automatic push_point(input logic act, input int x, input int y);
    point_beat_t b;
    b.action = act;
    b.px = 16'(x);
    b.py = 16'(y);
    pending_q.push_back(b);
  endtask

  // wait until every queued beat has been sent and answered
  task automatic drain();
    while (pending_q.size() > 0 || in_valid_i || centroid_q.size() > 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // apb write of the tolerance register, setup then access cycle
  task automatic write_tolerance(input logic [63:0] v);
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= '0;
    pwdata <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    tol_sq = v[ncpc_pkg::TolBits-1:0];
  endtask

  // random beat: mostly points near a few centers, some noise, rare clears
  task automatic push_random(input int spread);
    int cxs[4] = '{0, 2000, -9000, 25000};
    int c, x, y;
    if ($urandom_range(59) == 0) begin
      push_point(1'b1, $urandom, $urandom);
    end else if ($urandom_range(9) < 2) begin
      push_point(1'b0, $urandom, $urandom);
    end else begin
      c = $urandom_range(3);
      x = cxs[c] + $signed($urandom_range(2 * spread)) - spread;
      y = -cxs[c] + $signed($urandom_range(2 * spread)) - spread;
      push_point(1'b0, x, y);
    end
  endtask

  initial begin
    logic [63:0] tol_set[5];
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    action_i = 1'b0;
    point_x_i = '0;
    point_y_i = '0;
    out_ready_i = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    tol_sq = 34'd32768;
    table_live = 0;
    quiet = 1'b0;
    hold_send = 1'b0;
    in_fire = 1'b0;
    errors = 0;
    cycles = 0;
    points_sent = 0;
    results_seen = 0;
    full_seen = 0;
    new_seen = 0;
    joined_seen = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: reset tolerance, extremes, joins, clear
    push_point(1'b0, 0, 0);
    push_point(1'b0, 1, 1);
    push_point(1'b0, -100, 100);
    push_point(1'b0, 32767, 32767);
    push_point(1'b0, -32768, -32768);
    push_point(1'b0, -32768, 32767);
    push_point(1'b0, 32767, -32768);
    push_point(1'b0, 32700, 32767);
    push_point(1'b1, -1, -1);
    push_point(1'b0, -3, 5);
    push_point(1'b0, -4, 6);
    drain();

    // largest tolerance: every point lands in the first cluster
    write_tolerance(64'hFFFF_FFFF_FFFF_FFFF);
    push_point(1'b1, 0, 0);
    push_point(1'b0, 32767, -32768);
    push_point(1'b0, -32768, 32767);
    push_point(1'b0, -32768, -32768);
    push_point(1'b0, 5, -7);
    drain();

    // zero tolerance: every point opens a cluster until the table is full
    write_tolerance(64'd0);
    push_point(1'b1, 0, 0);
    for (int i = 0; i < ncpc_pkg::MaxClusters + 3; i++) push_point(1'b0, $urandom, $urandom);
    drain();

    // random phases over several tolerances, one stretch without idling
    tol_set = '{64'd32768, 64'd4000000, 64'd1, 64'd400000000, 64'h3_FFFF_FFFF};
    foreach (tol_set[p]) begin
      write_tolerance(tol_set[p]);
      quiet = (p == 1);
      push_point(1'b1, 0, 0);
      for (int i = 0; i < 252; i++) begin
        push_random((p == 1) ? 3000 : 400);
        if (i == 126) begin
          // let everything in flight come back before sending more
          while (pending_q.size() > 0 || in_valid_i) @(posedge clk_i);
          hold_send = 1'b1;
          while (centroid_q.size() > 0) @(posedge clk_i);
          hold_send = 1'b0;
        end
      end
      drain();
    end
    quiet = 1'b0;

    $display("covered %0d beats: %0d new clusters, %0d joins, %0d full-table drops",
             points_sent, new_seen, joined_seen, full_seen);
    $display("tolerance swept from zero to the 34-bit maximum, with clears in between");
    if (errors == 0 && centroid_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/ncpc_pkg.sv
rtl/core/nearest_centroid_point_clusterer.sv
sim/nearest_centroid_point_clusterer_tb.sv
